FILE: hw/rtl/fsymv_pkg.sv
// ----------------------------------------------------------------------------
// fsymv_pkg: shared types and constants for the fused SYMV column panel
// Panel geometry, Q16.16 arithmetic widths, register map and saturation.
// ----------------------------------------------------------------------------
package fsymv_pkg;

  // Panel width in use and number of column ports.
  localparam int unsigned COLS      = 4;
  localparam int unsigned MAX_COLS  = 4;
  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned SUM_W   = 52;
  localparam int unsigned ROW_W   = 3;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned REG_W   = 3;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [ROW_W-1:0]         row_t;

  typedef enum logic [REG_W-1:0] {
    REG_X_NORMAL0 = 3'd0,
    REG_X_NORMAL1 = 3'd1,
    REG_X_NORMAL2 = 3'd2,
    REG_X_NORMAL3 = 3'd3,
    REG_TRIANGLE  = 3'd4,
    REG_SUBTRACT  = 3'd5
  } reg_idx_e;

  localparam sum_t SAT_MAX = {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam sum_t SAT_MIN = {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  // Clamp a wide signed sum into the signed 32-bit range.
  function automatic data_t sat32(input sum_t v);
    data_t r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[DATA_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/fused_symv_column_panel_top.sv
// ----------------------------------------------------------------------------
// fused_symv_column_panel_top: fused SYMV column panel, Q16.16
// One matrix row per item; normal dot product out per row, transposed sums
// out on the last row of the panel.
// ----------------------------------------------------------------------------
// The block takes one row of a four-column panel of a symmetric matrix per
// item and returns one result item per row, in order. It accepts one item
// every clock cycle while in_stall_o is low; each item passes the input,
// product and result registers. The rate is set by the four 32x33 normal
// and four 32x32 transposed multipliers in the product stage, which work on
// a full row at once, and by the 48-bit transposed accumulators, which take
// one add per row. While a result waits on out_stall_i the output register
// holds it, and the input and product registers still take up to two more
// items before in_stall_o rises. The user must write configuration through
// the APB port only while no item is in flight; the block does not check it.
module fused_symv_column_panel_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // APB configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fsymv_pkg::PADDR_W-1:0]   paddr,
  input  logic [fsymv_pkg::DATA_W-1:0]    pwdata,
  output logic [fsymv_pkg::DATA_W-1:0]    prdata,
  output logic                            pready,
  // input item channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [fsymv_pkg::DATA_W-1:0] a_col0_i,
  input  logic signed [fsymv_pkg::DATA_W-1:0] a_col1_i,
  input  logic signed [fsymv_pkg::DATA_W-1:0] a_col2_i,
  input  logic signed [fsymv_pkg::DATA_W-1:0] a_col3_i,
  input  logic signed [fsymv_pkg::DATA_W-1:0] y_normal_in_i,
  input  logic signed [fsymv_pkg::DATA_W-1:0] x_trans_in_i,
  input  logic                            last_row_i,
  input  logic signed [fsymv_pkg::DATA_W-1:0] yt_in0_i,
  input  logic signed [fsymv_pkg::DATA_W-1:0] yt_in1_i,
  input  logic signed [fsymv_pkg::DATA_W-1:0] yt_in2_i,
  input  logic signed [fsymv_pkg::DATA_W-1:0] yt_in3_i,
  // result item channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [fsymv_pkg::DATA_W-1:0] y_normal_out_o,
  output logic signed [fsymv_pkg::DATA_W-1:0] yt_out0_o,
  output logic signed [fsymv_pkg::DATA_W-1:0] yt_out1_o,
  output logic signed [fsymv_pkg::DATA_W-1:0] yt_out2_o,
  output logic signed [fsymv_pkg::DATA_W-1:0] yt_out3_o,
  output logic                            done_res_o
);
  import fsymv_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  data_t x_normal_q [MAX_COLS];
  logic  triangle_q;
  logic  subtract_q;

  reg_idx_e reg_idx;
  logic     cfg_wr;

  assign reg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_COLS; j++) begin
        x_normal_q[j] <= '0;
      end
      triangle_q <= 1'b0;
      subtract_q <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_X_NORMAL0: x_normal_q[0] <= pwdata;
        REG_X_NORMAL1: x_normal_q[1] <= pwdata;
        REG_X_NORMAL2: x_normal_q[2] <= pwdata;
        REG_X_NORMAL3: x_normal_q[3] <= pwdata;
        REG_TRIANGLE:  triangle_q    <= pwdata[0];
        REG_SUBTRACT:  subtract_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_X_NORMAL0: prdata = x_normal_q[0];
      REG_X_NORMAL1: prdata = x_normal_q[1];
      REG_X_NORMAL2: prdata = x_normal_q[2];
      REG_X_NORMAL3: prdata = x_normal_q[3];
      REG_TRIANGLE:  prdata = {{(DATA_W-1){1'b0}}, triangle_q};
      REG_SUBTRACT:  prdata = {{(DATA_W-1){1'b0}}, subtract_q};
      default:       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or drains.
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_load, s2_load, s3_load;
  logic s1_move, s2_move;

  assign s3_load    = !s3_valid_q || !out_stall_i;
  assign s2_load    = !s2_valid_q || s3_load;
  assign s1_load    = !s1_valid_q || s2_load;
  assign s1_move    = s1_valid_q && s2_load;
  assign s2_move    = s2_valid_q && s3_load;
  assign in_stall_o = !s1_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_load) s1_valid_q <= in_valid_i;
      if (s2_load) s2_valid_q <= s1_valid_q;
      if (s3_load) s3_valid_q <= s2_valid_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: input register
  // --------------------------------------------------------------------------
  data_t s1_a_q [MAX_COLS];
  data_t s1_yt_q [MAX_COLS];
  data_t s1_y_q;
  data_t s1_xt_q;
  logic  s1_last_q;

  always_ff @(posedge clk_i) begin
    if (s1_load && in_valid_i) begin
      s1_a_q[0]  <= a_col0_i;
      s1_a_q[1]  <= a_col1_i;
      s1_a_q[2]  <= a_col2_i;
      s1_a_q[3]  <= a_col3_i;
      s1_yt_q[0] <= yt_in0_i;
      s1_yt_q[1] <= yt_in1_i;
      s1_yt_q[2] <= yt_in2_i;
      s1_yt_q[3] <= yt_in3_i;
      s1_y_q     <= y_normal_in_i;
      s1_xt_q    <= x_trans_in_i;
      s1_last_q  <= last_row_i;
    end
  end

  // --------------------------------------------------------------------------
  // Row position inside the panel, saturating at COLS; advance per row,
  // back to the first row after the last one.
  // --------------------------------------------------------------------------
  row_t row_q, row_d;
  logic corner;

  assign corner = triangle_q && (row_q < row_t'(COLS));

  always_comb begin
    row_d = row_q;
    if (s1_last_q) begin
      row_d = '0;
    end else if (row_q < row_t'(COLS)) begin
      row_d = row_q + row_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (s1_move) begin
      row_q <= row_d;
    end
  end

  // --------------------------------------------------------------------------
  // Products: a*xn and a*xt, shifted by FRAC_BITS and wrapped to 48 bits.
  // Diagonal-block rows drop columns left of the diagonal; normal also drops it.
  // --------------------------------------------------------------------------
  acc_t pn_d [MAX_COLS];
  acc_t pt_d [MAX_COLS];

  always_comb begin
    logic signed [DATA_W:0]     xn;
    logic signed [2*DATA_W:0]   pn_full;
    logic signed [2*DATA_W-1:0] pt_full;
    logic                       use_n;
    logic                       use_t;
    for (int j = 0; j < MAX_COLS; j++) begin
      xn = {x_normal_q[j][DATA_W-1], x_normal_q[j]};
      if (subtract_q) begin
        xn = -xn;
      end
      pn_full = s1_a_q[j] * xn;
      pt_full = s1_a_q[j] * s1_xt_q;
      pn_full = pn_full >>> FRAC_BITS;
      pt_full = pt_full >>> FRAC_BITS;
      use_n = (j < COLS) && (!corner || (row_t'(j) > row_q));
      use_t = (j < COLS) && (!corner || (row_t'(j) >= row_q));
      pn_d[j] = use_n ? pn_full[ACC_W-1:0] : '0;
      pt_d[j] = use_t ? pt_full[ACC_W-1:0] : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: product register
  // --------------------------------------------------------------------------
  acc_t  s2_pn_q [MAX_COLS];
  acc_t  s2_pt_q [MAX_COLS];
  data_t s2_yt_q [MAX_COLS];
  data_t s2_y_q;
  logic  s2_last_q;

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      for (int j = 0; j < MAX_COLS; j++) begin
        s2_pn_q[j] <= pn_d[j];
        s2_pt_q[j] <= pt_d[j];
        s2_yt_q[j] <= s1_yt_q[j];
      end
      s2_y_q    <= s1_y_q;
      s2_last_q <= s1_last_q;
    end
  end

  // --------------------------------------------------------------------------
  // Sums: normal dot product, transposed accumulators, final results.
  // --------------------------------------------------------------------------
  acc_t  acc_q [MAX_COLS];
  acc_t  acc_sum [MAX_COLS];
  acc_t  acc_d [MAX_COLS];
  data_t y_sat;
  data_t yt_sat [MAX_COLS];

  always_comb begin
    sum_t y_sum;
    sum_t yt_sum;
    y_sum = SUM_W'(s2_y_q);
    for (int j = 0; j < MAX_COLS; j++) begin
      y_sum      = y_sum + SUM_W'(s2_pn_q[j]);
      acc_sum[j] = acc_q[j] + s2_pt_q[j];
      if (subtract_q) begin
        yt_sum = SUM_W'(s2_yt_q[j]) - SUM_W'(acc_sum[j]);
      end else begin
        yt_sum = SUM_W'(s2_yt_q[j]) + SUM_W'(acc_sum[j]);
      end
      yt_sat[j] = (s2_last_q && (j < COLS)) ? sat32(yt_sum) : '0;
      acc_d[j]  = s2_last_q ? '0 : acc_sum[j];
    end
    y_sat = sat32(y_sum);
  end

  // Clear the accumulators once the last row of a panel has gone through.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_COLS; j++) begin
        acc_q[j] <= '0;
      end
    end else if (s2_move) begin
      for (int j = 0; j < MAX_COLS; j++) begin
        acc_q[j] <= acc_d[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: result register; hold while the consumer stalls.
  // --------------------------------------------------------------------------
  data_t s3_y_q;
  data_t s3_yt_q [MAX_COLS];
  logic  s3_done_q;

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      s3_y_q    <= y_sat;
      s3_done_q <= s2_last_q;
      for (int j = 0; j < MAX_COLS; j++) begin
        s3_yt_q[j] <= yt_sat[j];
      end
    end
  end

  assign out_valid_o    = s3_valid_q;
  assign y_normal_out_o = s3_y_q;
  assign yt_out0_o      = s3_yt_q[0];
  assign yt_out1_o      = s3_yt_q[1];
  assign yt_out2_o      = s3_yt_q[2];
  assign yt_out3_o      = s3_yt_q[3];
  assign done_res_o     = s3_done_q;

endmodule
